### src/apf_pkg.sv
// shared types, constants and limit derivation for the autofire pulse filter
package apf_pkg;

    // counter width and derived widths
    localparam int TIME_WIDTH = 16;
    localparam int LIM_W      = 16;
    localparam int CMP_W      = (TIME_WIDTH > LIM_W) ? TIME_WIDTH : LIM_W;
    localparam int SUM_W      = CMP_W + 1;

    // configuration port
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 2'd2;

    // register reset values
    localparam logic [LIM_W-1:0] RATE_RESET    = 16'd50;
    localparam logic [LIM_W-1:0] DELAY_RESET   = 16'd0;
    localparam logic [CFG_W-1:0] SUSTAIN_RESET = 17'h1FFFF;

    // default high time when sustain is negative
    localparam logic [LIM_W-1:0] DEFAULT_HIGH = 16'd50;

    // item kinds
    localparam logic FUNC_TICK   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // pulse phases
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_DELAY = 2'd1,
        PH_HIGH  = 2'd2,
        PH_LOW   = 2'd3
    } phase_t;

    // per-phase limits
    typedef struct packed {
        logic [LIM_W-1:0] delay;
        logic [LIM_W-1:0] high;
        logic [LIM_W-1:0] low;
    } limits_t;

    // derive delay, high and low times from the register values
    function automatic limits_t derive_limits(
        input logic [LIM_W-1:0] rate_ms,
        input logic [LIM_W-1:0] delay_ms,
        input logic [CFG_W-1:0] sustain_ms
    );
        limits_t          lim;
        logic [LIM_W-1:0] rate;
        logic [LIM_W-1:0] half;
        logic [LIM_W-1:0] high;
        rate = (rate_ms == '0) ? LIM_W'(1) : rate_ms;
        half = rate >> 1;
        if (sustain_ms[CFG_W-1])
        begin
            high = (half < DEFAULT_HIGH) ? DEFAULT_HIGH : half;
        end
        else
        begin
            high = sustain_ms[LIM_W-1:0];
        end
        if (high == '0)
        begin
            high = LIM_W'(1);
        end
        if (high >= rate)
        begin
            high = (rate > LIM_W'(1)) ? (rate - LIM_W'(1)) : LIM_W'(1);
        end
        lim.delay = delay_ms;
        lim.high  = high;
        lim.low   = rate - high;
        return lim;
    endfunction

endpackage

### src/apf_cfg.sv
// configuration registers and registered phase limits
module apf_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [apf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [apf_pkg::CFG_W-1:0]      cfg_data,
    output apf_pkg::limits_t               limits
);
    import apf_pkg::*;

    logic [LIM_W-1:0] rate_reg;
    logic [LIM_W-1:0] delay_reg;
    logic [CFG_W-1:0] sustain_reg;
    limits_t          limits_reg;
    limits_t          limits_next;

    // register writes; an index beyond the list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg    <= RATE_RESET;
            delay_reg   <= DELAY_RESET;
            sustain_reg <= SUSTAIN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RATE:    rate_reg    <= cfg_data[LIM_W-1:0];
                CFG_DELAY:   delay_reg   <= cfg_data[LIM_W-1:0];
                CFG_SUSTAIN: sustain_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // limit derivation
    always_comb
    begin
        limits_next = derive_limits(rate_reg, delay_reg, sustain_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg <= derive_limits(RATE_RESET, DELAY_RESET, SUSTAIN_RESET);
        end
        else
        begin
            limits_reg <= limits_next;
        end
    end

    assign limits = limits_reg;

endmodule

### src/apf_core.sv
// input register, pulse state update and result register
module apf_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  apf_pkg::limits_t               limits,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           func,
    input  logic                           button,
    input  logic [15:0]                    delta_ms,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           level
);
    import apf_pkg::*;

    localparam logic [SUM_W-1:0] TIME_MAX = SUM_W'((64'd1 << TIME_WIDTH) - 64'd1);

    // input stage
    logic                   s1_valid_reg;
    logic                   s1_func_reg;
    logic                   s1_button_reg;
    logic [15:0]            s1_delta_reg;

    // pulse state and result
    logic                   held_reg;
    logic                   held_next;
    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic [TIME_WIDTH-1:0]  elapsed_reg;
    logic [TIME_WIDTH-1:0]  elapsed_next;
    logic                   out_valid_reg;
    logic                   level_reg;
    logic                   level_next;

    logic                   out_ready;
    logic                   s1_fire;
    logic                   in_take;
    logic [SUM_W-1:0]       sum;
    logic [SUM_W-1:0]       sat;
    logic [LIM_W-1:0]       limit;

    // flow control: ticks always retire, samples need room in the result register
    assign out_ready = !out_valid_reg || !out_stall;
    assign s1_fire   = s1_valid_reg && ((s1_func_reg == FUNC_TICK) || out_ready);
    assign in_stall  = s1_valid_reg && !s1_fire;
    assign in_take   = in_valid && !in_stall;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_func_reg   <= func;
            s1_button_reg <= button;
            s1_delta_reg  <= delta_ms;
        end
    end

    // saturating counter add
    assign sum = SUM_W'(elapsed_reg) + SUM_W'(s1_delta_reg);
    assign sat = (sum > TIME_MAX) ? TIME_MAX : sum;

    // limit of the current phase
    always_comb
    begin
        unique case (phase_reg)
            PH_DELAY: limit = limits.delay;
            PH_HIGH:  limit = limits.high;
            PH_LOW:   limit = limits.low;
            default:  limit = '0;
        endcase
    end

    // next state for the transaction in the input register
    always_comb
    begin
        held_next    = held_reg;
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        level_next   = 1'b0;
        if (s1_func_reg == FUNC_TICK)
        begin
            if (held_reg && (phase_reg != PH_IDLE))
            begin
                if (sat >= SUM_W'(limit))
                begin
                    phase_next   = (phase_reg == PH_LOW) ? PH_HIGH : PH_LOW;
                    elapsed_next = '0;
                end
                else
                begin
                    elapsed_next = sat[TIME_WIDTH-1:0];
                end
            end
        end
        else if (!s1_button_reg)
        begin
            held_next    = 1'b0;
            phase_next   = PH_IDLE;
            elapsed_next = '0;
            level_next   = 1'b0;
        end
        else
        begin
            if (!held_reg)
            begin
                held_next    = 1'b1;
                elapsed_next = '0;
                phase_next   = (limits.delay != '0) ? PH_DELAY : PH_HIGH;
            end
            level_next = (phase_next != PH_LOW);
        end
    end

    // state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= 1'b0;
            phase_reg     <= PH_IDLE;
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
            level_reg     <= 1'b0;
        end
        else
        begin
            if (s1_fire)
            begin
                held_reg    <= held_next;
                phase_reg   <= phase_next;
                elapsed_reg <= elapsed_next;
            end
            if (s1_fire && (s1_func_reg == FUNC_SAMPLE))
            begin
                out_valid_reg <= 1'b1;
                level_reg     <= level_next;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign level     = level_reg;

endmodule

### src/autofire_pulse_filter.sv
// autofire pulse filter: an accepted sample passes the input register, then the result register
// throughput one transaction per cycle while no stall holds the input register; the counter add,
// limit compare and phase update are combinational between the input register and the state register
// ticks give no result; samples stall only while the result register is full and out_stall is high
// reset: not held, idle phase, counter 0, rate 50, delay 0, sustain -1
// config writes reach the phase limits through the config registers and then a limit register
module autofire_pulse_filter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [apf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [apf_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           func,
    input  logic                           button,
    input  logic [15:0]                    delta_ms,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           level
);
    import apf_pkg::*;

    limits_t limits;

    // configuration and derived limits
    apf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .limits    (limits)
    );

    // pulse state machine and handshakes
    apf_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .limits    (limits),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .button    (button),
        .delta_ms  (delta_ms),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .level     (level)
    );

endmodule
